// ----- hdl/sofi_pkg.sv -----
// ----------------------------------------------------------------------------
// sofi_pkg
// Shared widths and the per-stage data record of the offset pipeline.
// ----------------------------------------------------------------------------
package sofi_pkg;

  localparam int unsigned INDEX_W  = 40;
  localparam int unsigned EXTENT_W = 32;
  localparam int unsigned STRIDE_W = 32;
  localparam int unsigned OFFSET_W = 48;
  localparam int unsigned REG_DIMS = 4;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned DIV_STEPS = INDEX_W;

  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_BASE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_BASE = 4'd4;

  typedef struct packed {
    logic [EXTENT_W-1:0] rem;
    logic [INDEX_W-1:0]  dvd;
    logic [INDEX_W-1:0]  orig;
    logic [OFFSET_W-1:0] acc;
  } stage_t;

endpackage

// ----- hdl/sofi_div_stage.sv -----
// ----------------------------------------------------------------------------
// sofi_div_stage
// One restoring division step: shift one dividend bit in, compare, subtract.
// ----------------------------------------------------------------------------
module sofi_div_stage
  import sofi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [EXTENT_W-1:0] extent,
  input  logic                valid_in,
  input  stage_t              data_in,
  output logic                valid_out,
  output stage_t              data_out
);

  logic [EXTENT_W:0] trial;
  logic [EXTENT_W:0] diff;
  logic              fits;
  stage_t            data_next;

  always_comb begin
    trial = {data_in.rem, data_in.dvd[INDEX_W-1]};
    diff  = trial - {1'b0, extent};
    fits  = trial >= {1'b0, extent};
    data_next      = data_in;
    data_next.rem  = fits ? diff[EXTENT_W-1:0] : trial[EXTENT_W-1:0];
    data_next.dvd  = {data_in.dvd[INDEX_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (en) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_out <= data_next;
    end
  end

endmodule

// ----- hdl/sofi_dim.sv -----
// ----------------------------------------------------------------------------
// sofi_dim
// One dimension: pipelined divide by the extent, then coordinate times
// stride in two partial products, then accumulate.
// ----------------------------------------------------------------------------
module sofi_dim
  import sofi_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic [EXTENT_W-1:0] extent,
  input  logic [STRIDE_W-1:0] stride,
  input  logic                valid_in,
  input  logic [INDEX_W-1:0]  rest_in,
  input  logic [OFFSET_W-1:0] acc_in,
  output logic                valid_out,
  output logic [INDEX_W-1:0]  rest_out,
  output logic [OFFSET_W-1:0] acc_out
);

  localparam int unsigned HI_W = INDEX_W - EXTENT_W;

  logic   [DIV_STEPS:0] sv;
  stage_t               sd [DIV_STEPS+1];

  assign sv[0]       = valid_in;
  assign sd[0].rem   = '0;
  assign sd[0].dvd   = rest_in;
  assign sd[0].orig  = rest_in;
  assign sd[0].acc   = acc_in;

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    sofi_div_stage u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .extent    (extent),
      .valid_in  (sv[s]),
      .data_in   (sd[s]),
      .valid_out (sv[s+1]),
      .data_out  (sd[s+1])
    );
  end

  logic                        ext_zero;
  logic [INDEX_W-1:0]          coord;
  logic signed [EXTENT_W:0]    coord_lo;
  logic signed [HI_W:0]        coord_hi;
  logic signed [EXTENT_W+STRIDE_W:0] prod_lo;
  logic signed [HI_W+STRIDE_W:0]     prod_hi;

  always_comb begin
    ext_zero = extent == '0;
    coord    = ext_zero ? sd[DIV_STEPS].orig : {{HI_W{1'b0}}, sd[DIV_STEPS].rem};
    coord_lo = $signed({1'b0, coord[EXTENT_W-1:0]});
    coord_hi = $signed({1'b0, coord[INDEX_W-1:EXTENT_W]});
    prod_lo  = coord_lo * $signed(stride);
    prod_hi  = coord_hi * $signed(stride);
  end

  logic                       mul_valid;
  logic [OFFSET_W-1:0]        mul_lo;
  logic [OFFSET_W-EXTENT_W-1:0] mul_hi;
  logic [OFFSET_W-1:0]        mul_acc;
  logic [INDEX_W-1:0]         mul_rest;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      mul_valid <= sv[DIV_STEPS];
      valid_out <= mul_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mul_lo   <= prod_lo[OFFSET_W-1:0];
      mul_hi   <= prod_hi[OFFSET_W-EXTENT_W-1:0];
      mul_acc  <= sd[DIV_STEPS].acc;
      mul_rest <= ext_zero ? '0 : sd[DIV_STEPS].dvd;
      acc_out  <= mul_acc + mul_lo + {mul_hi, {EXTENT_W{1'b0}}};
      rest_out <= mul_rest;
    end
  end

endmodule

// ----- hdl/strided_offset_from_flat_index.sv -----
// ----------------------------------------------------------------------------
// strided_offset_from_flat_index
// Flat element index to signed strided memory offset.
// ----------------------------------------------------------------------------
// Takes one index per cycle and returns one 48-bit offset per index, in order.
// Each of the min(NUM_DIMS, 4) walked dimensions has 40 one-bit divide steps by
// the extent, one multiply stage and one accumulate stage; throughput is one
// item per cycle while result_stall does not hold a finished offset. The whole
// pipeline holds while a finished offset waits under result_stall. Write the
// registers only while the pipeline is empty.
module strided_offset_from_flat_index
  import sofi_pkg::*;
#(
  parameter int unsigned NUM_DIMS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [EXTENT_W-1:0]  cfg_data,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [INDEX_W-1:0]   linear_index,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic [OFFSET_W-1:0]  element_offset
);

  localparam int unsigned WALK = (NUM_DIMS < REG_DIMS) ? NUM_DIMS : REG_DIMS;

  logic [EXTENT_W-1:0] extent [REG_DIMS];
  logic [STRIDE_W-1:0] stride [REG_DIMS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < REG_DIMS; d++) begin
        extent[d] <= EXTENT_W'(1);
        stride[d] <= '0;
      end
    end else if (cfg_write) begin
      for (int d = 0; d < REG_DIMS; d++) begin
        if (cfg_index == REG_EXTENT_BASE + CFG_IDX_W'(d)) begin
          extent[d] <= cfg_data;
        end
        if (cfg_index == REG_STRIDE_BASE + CFG_IDX_W'(d)) begin
          stride[d] <= cfg_data;
        end
      end
    end
  end

  logic en;
  assign en         = !(result_valid && result_stall);
  assign item_stall = !en;

  logic [WALK:0]       dv;
  logic [INDEX_W-1:0]  dr [WALK+1];
  logic [OFFSET_W-1:0] da [WALK+1];

  assign dv[0] = item_valid;
  assign dr[0] = linear_index;
  assign da[0] = '0;

  for (genvar k = 0; k < WALK; k++) begin : g_dim
    sofi_dim u_dim (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .extent    (extent[REG_DIMS-1-k]),
      .stride    (stride[REG_DIMS-1-k]),
      .valid_in  (dv[k]),
      .rest_in   (dr[k]),
      .acc_in    (da[k]),
      .valid_out (dv[k+1]),
      .rest_out  (dr[k+1]),
      .acc_out   (da[k+1])
    );
  end

  assign result_valid   = dv[WALK];
  assign element_offset = da[WALK];

  a_stall_match: assert property (@(posedge clk) disable iff (rst)
    item_stall == (result_valid && result_stall))
    else $error("input stall does not follow output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> $stable(element_offset))
    else $error("stalled result changed");

endmodule
